// File: hdl/bgs_pkg.sv
`default_nettype none
package bgs_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int FIFO_DEPTH_DEF = 4;
  localparam int WIDTH_RESET    = 2048;
  localparam int HEIGHT_RESET   = 2;

  localparam int CH_W        = 8;
  localparam int NUM_CH      = 4;
  localparam int PIX_W       = CH_W * NUM_CH;
  localparam int GRAD_CH_W   = CH_W + 1;
  localparam int GRAD_W      = GRAD_CH_W * NUM_CH;
  localparam int COL_W       = 11;
  localparam int ROW_W       = 16;
  localparam int IMG_WIDTH_W = 12;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = COL_W + ROW_W + 2 * GRAD_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [GRAD_W-1:0] grad_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // index of the last result carried by one queue entry
  typedef enum logic [1:0] {
    RES_LAST0 = 2'd0,
    RES_LAST1 = 2'd1,
    RES_LAST2 = 2'd2
  } res_last_t;

  // one accepted pixel worth of results, front to back
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] col_left;
    logic [ROW_W-1:0] row_up;
    logic [ROW_W-1:0] row;
    grad_t            hg;
    grad_t            vg;
    grad_t            hl;
    grad_t            lvg;
    res_last_t        last_idx;
  } bgs_entry_t;

  // per-channel a - b, 9 bit two's complement per channel
  function automatic grad_t diff4(input pixel_t a, input pixel_t b);
    grad_t r;
    for (int c = 0; c < NUM_CH; c++) begin
      r[c*GRAD_CH_W +: GRAD_CH_W] = {1'b0, a[c*CH_W +: CH_W]} - {1'b0, b[c*CH_W +: CH_W]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/bgs_fifo.sv
`default_nettype none
module bgs_fifo
  import bgs_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire bgs_entry_t push_data,
  output logic            ready,
  input  wire logic       pop,
  output bgs_entry_t      head,
  output logic            valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  bgs_entry_t      slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign ready = (count != CNTW'(DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && !ready))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && !valid))
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) count <= CNTW'(DEPTH))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// File: hdl/bgs_front.sv
`default_nettype none
module bgs_front
  import bgs_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,
  input  wire logic                  q_ready,
  output logic                       q_push,
  output bgs_entry_t                 q_entry
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1 + IMG_WIDTH_W;
  localparam int W_RST = (MAX_WIDTH < WIDTH_RESET) ? MAX_WIDTH : WIDTH_RESET;

  // effective last column and last row
  logic [CW-1:0]    w_last;
  logic [CW-1:0]    w_last_next;
  logic [ROW_W-1:0] h_last;
  logic [ROW_W-1:0] h_last_next;
  logic [WW-1:0]    wv;

  always_comb begin
    wv = WW'(cfg_data[IMG_WIDTH_W-1:0]);
    if (wv < WW'(2)) begin
      w_last_next = CW'(1);
    end else if (wv > WW'(MAX_WIDTH)) begin
      w_last_next = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_next = CW'(wv - 1'b1);
    end
    h_last_next = (cfg_data < CFG_DATA_W'(2)) ? ROW_W'(1) : ROW_W'(cfg_data - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= CW'(W_RST - 1);
      h_last <= ROW_W'(HEIGHT_RESET - 1);
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        w_last <= w_last_next;
      end else begin
        h_last <= h_last_next;
      end
    end
  end

  // position of the incoming pixel
  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [CW-1:0]    x;
  logic [ROW_W-1:0] y;
  logic             acc;
  logic             at_last_col;
  logic             at_last_row;
  pixel_t           left_pixel;

  assign x   = (col_count > w_last) ? w_last : col_count;
  assign y   = (row_count > h_last) ? h_last : row_count;
  assign acc = s_tvalid && s_tready;
  assign at_last_col = (x == w_last);
  assign at_last_row = (y == h_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      left_pixel <= '0;
    end else if (acc) begin
      left_pixel <= s_tdata;
      if (at_last_col) begin
        col_count <= '0;
        row_count <= at_last_row ? '0 : y + 1'b1;
      end else begin
        col_count <= x + 1'b1;
        row_count <= y;
      end
    end
  end

  // previous row pixels, read at x and x+1 before x is overwritten
  pixel_t row_pixels [MAX_WIDTH];
  pixel_t rd_up;
  pixel_t rd_next;
  grad_t  row_hgrads [MAX_WIDTH];
  grad_t  rd_hg;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_up         <= row_pixels[x];
      rd_next       <= row_pixels[CW'(x + 1'b1)];
      row_pixels[x] <= s_tdata;
    end
  end

  // compute stage
  logic             s1_valid;
  pixel_t           s1_cur;
  pixel_t           s1_left;
  logic [CW-1:0]    s1_x;
  logic [ROW_W-1:0] s1_y;
  logic             s1_emit;
  logic             s1_last_col;
  logic             s1_last_row;
  logic             s1_fire;

  assign s1_fire  = s1_valid && (!s1_emit || q_ready);
  assign s_tready = !s1_valid || s1_fire;
  assign q_push   = s1_valid && s1_emit && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cur      <= s_tdata;
      s1_left     <= left_pixel;
      s1_x        <= x;
      s1_y        <= y;
      s1_emit     <= (y != '0);
      s1_last_col <= at_last_col;
      s1_last_row <= at_last_row;
    end
  end

  // last written horizontal gradient, covers a write in the read cycle
  logic          byp_valid;
  logic [CW-1:0] byp_addr;
  grad_t         byp_data;
  grad_t         left_vgrad;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_hg <= row_hgrads[CW'(x - 1'b1)];
    end
    if (q_push) begin
      row_hgrads[s1_x] <= q_entry.hg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid  <= 1'b0;
      left_vgrad <= '0;
    end else if (q_push) begin
      byp_valid  <= 1'b1;
      left_vgrad <= q_entry.vg;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      byp_addr <= s1_x;
      byp_data <= q_entry.hg;
    end
  end

  logic [CW-1:0]       x_left;
  logic [CW+COL_W-1:0] x_ext;
  logic [CW+COL_W-1:0] xl_ext;
  grad_t               hg_prev;

  always_comb begin
    x_left  = s1_x - 1'b1;
    x_ext   = (CW+COL_W)'(s1_x);
    xl_ext  = (CW+COL_W)'(x_left);
    hg_prev = (byp_valid && byp_addr == x_left) ? byp_data : rd_hg;

    q_entry.col      = x_ext[COL_W-1:0];
    q_entry.col_left = xl_ext[COL_W-1:0];
    q_entry.row_up   = s1_y - 1'b1;
    q_entry.row      = s1_y;
    q_entry.vg       = diff4(s1_cur, rd_up);
    q_entry.hg       = s1_last_col ? hg_prev : diff4(rd_next, rd_up);
    q_entry.hl       = diff4(s1_cur, s1_left);
    q_entry.lvg      = left_vgrad;
    if (s1_last_row && s1_x != '0) begin
      q_entry.last_idx = s1_last_col ? RES_LAST2 : RES_LAST1;
    end else begin
      q_entry.last_idx = RES_LAST0;
    end
  end

endmodule
`default_nettype wire

// File: hdl/bgs_back.sv
`default_nettype none
module bgs_back
  import bgs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire bgs_entry_t             q_entry,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic                        m_tlast
);

  res_last_t                idx;
  res_last_t                idx_next;
  logic                     load;
  logic [COL_W-1:0]         sel_col;
  logic [ROW_W-1:0]         sel_row;
  grad_t                    sel_gx;
  grad_t                    sel_gy;
  logic                     sel_done;

  assign load  = q_valid && (!m_tvalid || m_tready);
  assign q_pop = load && (idx == q_entry.last_idx);

  always_comb begin
    case (idx)
      RES_LAST1: begin
        sel_col  = q_entry.col_left;
        sel_row  = q_entry.row;
        sel_gx   = q_entry.hl;
        sel_gy   = q_entry.lvg;
        sel_done = 1'b0;
        idx_next = RES_LAST2;
      end
      RES_LAST2: begin
        sel_col  = q_entry.col;
        sel_row  = q_entry.row;
        sel_gx   = q_entry.hl;
        sel_gy   = q_entry.vg;
        sel_done = 1'b1;
        idx_next = RES_LAST0;
      end
      default: begin
        sel_col  = q_entry.col;
        sel_row  = q_entry.row_up;
        sel_gx   = q_entry.hg;
        sel_gy   = q_entry.vg;
        sel_done = 1'b0;
        idx_next = RES_LAST1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= RES_LAST0;
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      idx      <= q_pop ? RES_LAST0 : idx_next;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= OUT_TDATA_W'({sel_gy, sel_gx, sel_row, sel_col});
      m_tlast <= sel_done;
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) idx != RES_LAST0 |-> q_valid)
    else $error("entry left the queue before all its beats went out");
  assert property (@(posedge clk) disable iff (rst)
    (load && idx == RES_LAST2) |=> (m_tvalid && m_tlast))
    else $error("frame end beat lost its last flag");

endmodule
`default_nettype wire

// File: hdl/bump_gradient_stream_core.sv
`default_nettype none
// forward difference gradient over an rgba pixel stream in raster order
// s_* carries one pixel per beat; m_* carries one result per beat:
//   position (col,row), horizontal and vertical difference per channel,
//   tlast high on the last result of the frame (bottom right pixel)
// results lag by one row: pixel (x,y), y>=1, yields (x,y-1); in the last row
//   it also yields (x-1,last row), and the last pixel of the frame also
//   yields (last col,last row); row 0 yields nothing
// image_width/image_height come in through cfg_we/cfg_index/cfg_data and
//   are clamped to 2..MAX_WIDTH and 2..65535; write them between frames
// throughput: one pixel per cycle while m_tready is high, limited in the
//   last row by the output port at one beat per cycle (two beats per pixel,
//   three on the last one); a result reaches m_tdata through the memory
//   read and compute stage, then the queue, then the output register
// the front part reads the line memory at x and x+1 and computes all
//   gradients, a short queue decouples it from the back part, which splits
//   each entry into one to three beats
// m_tready low: the output register holds, the queue fills, then s_tready
//   drops; no beat is lost
// reset: counters back to the top left pixel, width 2048 (or MAX_WIDTH),
//   height 2; line memories are not cleared and need no clearing pass
module bump_gradient_stream_core
  import bgs_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // pixel_red, pixel_green, pixel_blue, pixel_alpha
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // out_col, out_row, grad_x_red, grad_x_green, grad_x_blue, grad_x_alpha,
  // grad_y_red, grad_y_green, grad_y_blue, grad_y_alpha, zero pad
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // frame_done
  output logic                        m_tlast
);

  logic       q_push;
  logic       q_ready;
  logic       q_pop;
  logic       q_valid;
  bgs_entry_t q_in;
  bgs_entry_t q_head;

  // counters, line memories and gradient math
  bgs_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // decoupling queue, one entry per pixel that yields results
  bgs_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .ready    (q_ready),
    .pop      (q_pop),
    .head     (q_head),
    .valid    (q_valid)
  );

  // entry to beats, output register
  bgs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_head),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule
`default_nettype wire

// File: verif/tb_bump_gradient_stream_core.sv
module tb_bump_gradient_stream_core;
  import bgs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int RANDOM_PIXELS   = 240;
  localparam int SETTLE_CYCLES   = 8;     // pipeline is three stages deep
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall, fills the queue
  localparam int MAX_MISMATCH_LOG = 10;

  // one expected result beat
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    grad_t            gx;
    grad_t            gy;
    logic             done;
  } grad_result_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  cfg_reg_t               cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  // pixel_red, pixel_green, pixel_blue, pixel_alpha
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  // out_col, out_row, grad_x_red .. grad_x_alpha, grad_y_red .. grad_y_alpha, zero pad
  logic [OUT_TDATA_W-1:0] m_tdata;
  // frame_done
  logic                   m_tlast;

  bump_gradient_stream_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // ---------------------------------------------------------------------------
  // gradient predictor state: line buffers, left neighbour, raster counters
  // and the two size registers as last written
  // ---------------------------------------------------------------------------
  pixel_t               prev_row_pix [MAX_WIDTH_DEF];
  grad_t                prev_row_hg  [MAX_WIDTH_DEF];
  pixel_t               left_pix  = '0;
  grad_t                left_vg   = '0;
  int                   col_pos   = 0;
  int                   row_pos   = 0;
  logic [IMG_WIDTH_W-1:0] width_reg  = IMG_WIDTH_W'(WIDTH_RESET);
  logic [ROW_W-1:0]       height_reg = ROW_W'(HEIGHT_RESET);

  grad_result_t pending_grads [$];

  // bookkeeping
  int    mismatches      = 0;
  int    results_checked = 0;
  int    frames_seen     = 0;
  int    pixels_sent     = 0;
  bit    no_idle         = 1'b0;   // both sides run without gaps
  bit    hold_off_req    = 1'b0;   // asks the sink for one long stall
  string chan_name [NUM_CH] = '{"red", "green", "blue", "alpha"};

  // ---------------------------------------------------------------------------
  // clock, reset, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous: the whole run needs well under a tenth of this
  initial begin
    #5_000_000;
    $display("bump_gradient_stream_core test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor helpers
  // ---------------------------------------------------------------------------
  // register values are clamped to the sizes the block can handle
  function automatic int eff_width();
    int w;
    w = int'(width_reg);
    if (w < 2) w = 2;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int eff_height();
    return (int'(height_reg) < 2) ? 2 : int'(height_reg);
  endfunction

  // per channel a - b as 9 bit two's complement, red in the low bits
  function automatic grad_t chan_diff(pixel_t a, pixel_t b);
    grad_t r;
    int    d;
    for (int c = 0; c < NUM_CH; c++) begin
      d = int'(a[c*CH_W +: CH_W]) - int'(b[c*CH_W +: CH_W]);
      r[c*GRAD_CH_W +: GRAD_CH_W] = d[GRAD_CH_W-1:0];
    end
    return r;
  endfunction

  // pixels still to come before the counters wrap to the top left
  function automatic int frame_pixels_left();
    int w, h, x, y;
    w = eff_width();
    h = eff_height();
    x = (col_pos < w) ? col_pos : w - 1;
    y = (row_pos < h) ? row_pos : h - 1;
    return (h - 1 - y) * w + (w - x);
  endfunction

  task automatic push_grad(int col, int row, grad_t gx, grad_t gy, logic done);
    grad_result_t r;
    r.col  = col[COL_W-1:0];
    r.row  = row[ROW_W-1:0];
    r.gx   = gx;
    r.gy   = gy;
    r.done = done;
    pending_grads.push_back(r);
  endtask

  // advance the model by one accepted pixel and queue what it yields
  task automatic predict_gradients(pixel_t pix);
    int     w, h, x, y;
    pixel_t up;
    grad_t  vg, hg, hl;
    w = eff_width();
    h = eff_height();
    // counters past a shrunken bound act as the last column/row
    x = (col_pos < w) ? col_pos : w - 1;
    y = (row_pos < h) ? row_pos : h - 1;
    if (y >= 1) begin
      up = prev_row_pix[x];
      vg = chan_diff(pix, up);
      // last column reuses the horizontal gradient of its left neighbour
      hg = (x < w - 1) ? chan_diff(prev_row_pix[x+1], up) : prev_row_hg[x-1];
      prev_row_hg[x] = hg;
      push_grad(x, y - 1, hg, vg, 1'b0);
      // last row: its gradients come one pixel late, vertical copied from above
      if (y == h - 1 && x >= 1) begin
        hl = chan_diff(pix, left_pix);
        push_grad(x - 1, y, hl, left_vg, 1'b0);
        if (x == w - 1) push_grad(x, y, hl, vg, 1'b1);
      end
      left_vg = vg;
    end
    prev_row_pix[x] = pix;
    left_pix = pix;
    if (x >= w - 1) begin
      col_pos = 0;
      row_pos = (y >= h - 1) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // one pixel beat; valid stays up into the next call unless a gap is drawn
  task automatic send_pixel(pixel_t pix);
    int gap;
    s_tdata  <= pix;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
    predict_gradients(pix);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = idle_len();
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pauses until every expected result is back, then lets the
  // pipeline settle since row 0 pixels leave no result behind
  task automatic wait_results();
    s_tvalid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both size registers, back to back; call only while idle
  task automatic write_sizes(logic [CFG_DATA_W-1:0] w_val, logic [CFG_DATA_W-1:0] h_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w_val;
    @(posedge clk);
    width_reg = w_val[IMG_WIDTH_W-1:0];
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h_val;
    @(posedge clk);
    height_reg = h_val;
    cfg_we    <= 1'b0;
  endtask

  // sink: random stalls, a long hold-off on request, none in no_idle stretches
  always begin : result_sink
    int n;
    @(posedge clk);
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      m_tready <= 1'b0;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      m_tready <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      n = idle_len();
      m_tready <= 1'b0;
      repeat (n) @(posedge clk);
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(string what, integer want, integer got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_MISMATCH_LOG)
        $display("mismatch in %s of result %0d: expected %0d, got %0d",
                 what, results_checked, want, got);
    end
  endtask

  // every result beat against the oldest expectation, field by field
  always @(posedge clk) begin : result_check
    grad_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (m_tlast) frames_seen++;
      if (pending_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_MISMATCH_LOG)
          $display("result %0d arrived with nothing expected (col %0d row %0d)",
                   results_checked, m_tdata[COL_W-1:0], m_tdata[COL_W +: ROW_W]);
      end else begin
        want = pending_grads.pop_front();
        check_field("out_col", want.col, m_tdata[COL_W-1:0]);
        check_field("out_row", want.row, m_tdata[COL_W +: ROW_W]);
        for (int c = 0; c < NUM_CH; c++) begin
          check_field({"grad_x_", chan_name[c]},
                      $signed(want.gx[c*GRAD_CH_W +: GRAD_CH_W]),
                      $signed(m_tdata[COL_W + ROW_W + c*GRAD_CH_W +: GRAD_CH_W]));
          check_field({"grad_y_", chan_name[c]},
                      $signed(want.gy[c*GRAD_CH_W +: GRAD_CH_W]),
                      $signed(m_tdata[COL_W + ROW_W + GRAD_W + c*GRAD_CH_W +: GRAD_CH_W]));
        end
        check_field("frame_done", want.done, m_tlast);
        check_field("tdata pad", 0, m_tdata[OUT_TDATA_W-1:OUT_FIELD_W]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // tiny frames, sizes written below the minimum or with ignored high bits,
  // pixels at the channel extremes so gradients reach +-255
  task automatic test_small_frames();
    pixel_t extremes [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_FF00, 32'h00FF_00FF};
    pixel_t ramps    [6] = '{32'h8040_2010, 32'h0102_0304, 32'hFE7F_01C0,
                             32'h1020_4080, 32'hFFFE_0001, 32'h00C0_7F3F};
    write_sizes(16'd1, 16'd0);            // clamps to 2 x 2
    foreach (extremes[i]) send_pixel(extremes[i]);
    wait_results();
    write_sizes(16'hF003, 16'd1);         // upper width bits ignored: 3 x 2
    foreach (ramps[i]) send_pixel(ramps[i]);
    wait_results();
    write_sizes(16'd0, 16'd3);            // 2 x 3
    repeat (6) send_pixel($urandom());
    wait_results();
  endtask

  // width above the maximum, so the row runs on past twelve columns; it is
  // then cut to twelve mid-row, which also leaves every line buffer entry
  // that the later resizes and random frames reach written
  task automatic test_widest_frame();
    write_sizes(16'h0FFF, 16'd2);         // clamps to MAX_WIDTH x 2
    repeat (12) send_pixel($urandom());   // row 0, no wrap yet
    wait_results();
    write_sizes(16'd12, 16'd2);           // column 12 now past the last column
    repeat (13) send_pixel($urandom());
    wait_results();
  endtask

  // sizes changed with the counters mid-frame: they act at once, a counter
  // past the new bound is taken as the last column or row
  task automatic test_mid_frame_resize();
    write_sizes(16'd4, 16'hFFFF);
    repeat (6) send_pixel($urandom());    // row 0 and half of row 1
    wait_results();
    write_sizes(16'd2, 16'hFFFF);         // column 2 now past the last column
    repeat (3) send_pixel($urandom());
    wait_results();
    write_sizes(16'd2, 16'd2);            // row 3 now past the last row
    repeat (2) send_pixel($urandom());
    wait_results();
  endtask

  // long output hold-off while pixels keep coming, then a pause mid-frame,
  // then a frame with no idling on either side
  task automatic test_backpressure();
    write_sizes(16'd5, 16'd4);
    no_idle      = 1'b1;
    hold_off_req = 1'b1;
    repeat (12) send_pixel($urandom());
    wait_results();
    repeat (8) send_pixel($urandom());
    wait_results();
    write_sizes(16'd3, 16'd3);
    repeat (9) send_pixel($urandom());
    no_idle = 1'b0;
    wait_results();
  endtask

  // mostly whole frames of random small sizes and content; some cut short
  // so the next sizes land mid-frame
  task automatic test_random_frames();
    int                    sent, left, n;
    logic [CFG_DATA_W-1:0] w_val, h_val;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      wait_results();
      case ($urandom_range(0, 9))
        0:       w_val = 16'($urandom_range(0, 1));
        1:       w_val = {4'($urandom()), 12'($urandom_range(2, 12))};
        default: w_val = 16'($urandom_range(2, 10));
      endcase
      case ($urandom_range(0, 9))
        0:       h_val = 16'($urandom_range(0, 1));
        1:       h_val = 16'hFFFF;
        default: h_val = 16'($urandom_range(2, 5));
      endcase
      write_sizes(w_val, h_val);
      left = frame_pixels_left();
      if (left > 64 || $urandom_range(0, 5) == 0)
        n = $urandom_range(1, (left < 24) ? left : 24);
      else
        n = left;
      repeat (n) send_pixel($urandom());
      sent += n;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_small_frames();
    test_widest_frame();
    test_mid_frame_resize();
    test_backpressure();
    test_random_frames();
    wait_results();
    $display("%0d pixels in, %0d gradient beats checked, %0d frames closed",
             pixels_sent, results_checked, frames_seen);
    $display("covered clamped sizes, a width above the maximum, mid-frame resizes, hold-off");
    if (mismatches == 0 && pending_grads.size() == 0) begin
      $display("bump_gradient_stream_core test passed");
    end else begin
      $display("bump_gradient_stream_core test failed");
    end
    $finish;
  end

endmodule
